/* rtl/core/gdfs_pkg.sv */
// shared types, codes and neighbour offset table for the grid depth-first search
package gdfs_pkg;

  localparam int EPOCH_W = 8;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_STARTED  = 3'd1;
  localparam logic [2:0] ST_MOVED    = 3'd2;
  localparam logic [2:0] ST_GOAL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       passable;
    logic [5:0] goal_row;
    logic [5:0] goal_col;
  } item_t;

  typedef struct packed {
    logic [5:0] pos_row;
    logic [5:0] pos_col;
    logic [3:0] pushed_count;
    logic [2:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MARK,
    S_NB_RD,
    S_NB_CHK,
    S_POP,
    S_POP_WAIT
  } state_t;

  // row offset for neighbour k: up-left, up, up-right, right, down-right, down, down-left, left
  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd7:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd6, 3'd7: d = -2'sd1;
      3'd1, 3'd5:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/grid_depth_first_search.sv */
// top level of the grid depth-first search: sequencer, state registers and maps
//
// One item at a time; busy is high while an item is in work and start is taken only
// when busy is low. A load, and a step that ends at once (inactive or already at the
// goal), finish in the idle state that takes them. A start goes on to S_MARK, through
// S_CLEAR first when the epoch wraps. A search step walks the eight neighbours: an
// in-bounds one passes S_NB_RD and S_NB_CHK through the shared neighbour unit and the
// registered map reads, an out-of-bounds one only S_NB_RD; then S_POP and S_POP_WAIT
// pop the stack, and S_POP alone ends the step when the stack runs empty. The result
// is shown with done for exactly one cycle, the cycle after the item finishes, and
// cannot be held off. The visited map is tagged with an 8-bit search epoch; after
// reset, and once every 255 starts when the epoch wraps, a clearing pass writes all
// 2**(2*clog2(MAX_SIDE)) visited entries (4096 at the default), with busy held high.
// Configuration writes are always ready.
module grid_depth_first_search #(
  parameter int MAX_SIDE = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gdfs_pkg::item_t item,
  output logic            done,
  output gdfs_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [6:0]      cfg_data
);
  import gdfs_pkg::*;

  localparam int AB       = $clog2(MAX_SIDE);
  localparam int CW       = (AB > 6) ? AB : 6;
  localparam int SW       = CW + 1;
  localparam int AW       = 2 * AB;
  localparam int DEPTH    = 1 << AW;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CNT_W    = AW + 1;
  localparam int SIDE_RST = (MAX_SIDE < 64) ? MAX_SIDE : 64;

  state_t             state, state_next;
  logic [2:0]         k, k_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic               clr_mark, clr_mark_next;
  logic [CW-1:0]      cur_row, cur_row_next;
  logic [CW-1:0]      cur_col, cur_col_next;
  logic [5:0]         goal_row, goal_row_next;
  logic [5:0]         goal_col, goal_col_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               active, active_next;
  logic [3:0]         pushed, pushed_next;
  logic [AW-1:0]      nb_addr, nb_addr_next;
  logic [SW-1:0]      side, side_next;
  logic               done_next;
  result_t            result_next;

  logic [CW-1:0]      r_ext, c_ext;
  logic [SW-1:0]      gs_ext;
  logic               load_ok;
  logic               nb_in;
  logic [AW-1:0]      nb_addr_c;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CW-1:0]      pop_row, pop_col;

  logic               pass_we;
  logic [AW-1:0]      pass_waddr;
  logic               pass_wdata;
  logic               pass_rd;
  logic               vis_we;
  logic [AW-1:0]      vis_waddr;
  logic [EPOCH_W-1:0] vis_wdata;
  logic [EPOCH_W-1:0] vis_rd;
  logic               stk_we;
  logic [AW-1:0]      stk_rd;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign r_ext     = CW'(item.cell_row);
  assign c_ext     = CW'(item.cell_col);
  assign gs_ext    = SW'(cfg_data);
  assign load_ok   = ({1'b0, r_ext} < SW'(MAX_SIDE)) && ({1'b0, c_ext} < SW'(MAX_SIDE));
  assign cnt_dec   = count - CNT_W'(1);
  assign pop_row   = CW'(stk_rd[AW-1:AB]);
  assign pop_col   = CW'(stk_rd[AB-1:0]);

  gdfs_nbr #(.MAX_SIDE(MAX_SIDE)) u_nbr (
    .cur_row  (cur_row),
    .cur_col  (cur_col),
    .k        (k),
    .side     (side),
    .in_bounds(nb_in),
    .addr     (nb_addr_c)
  );

  gdfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pass_ram (
    .clk    (clk),
    .wr_en  (pass_we),
    .wr_addr(pass_waddr),
    .wr_data(pass_wdata),
    .rd_addr(nb_addr_c),
    .rd_data(pass_rd)
  );

  gdfs_ram #(.WIDTH(EPOCH_W), .DEPTH(DEPTH)) u_vis_ram (
    .clk    (clk),
    .wr_en  (vis_we),
    .wr_addr(vis_waddr),
    .wr_data(vis_wdata),
    .rd_addr(nb_addr_c),
    .rd_data(vis_rd)
  );

  gdfs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack_ram (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(count[AW-1:0]),
    .wr_data(nb_addr),
    .rd_addr(cnt_dec[AW-1:0]),
    .rd_data(stk_rd)
  );

  always_comb begin
    if (cfg_valid && cfg_ready) begin
      if (gs_ext == '0) begin
        side_next = SW'(1);
      end else if (gs_ext > SW'(MAX_SIDE)) begin
        side_next = SW'(MAX_SIDE);
      end else begin
        side_next = gs_ext;
      end
    end else begin
      side_next = side;
    end
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    epoch_next    = epoch;
    clr_addr_next = clr_addr;
    clr_mark_next = clr_mark;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    goal_row_next = goal_row;
    goal_col_next = goal_col;
    count_next    = count;
    active_next   = active;
    pushed_next   = pushed;
    nb_addr_next  = nb_addr;
    done_next     = 1'b0;
    result_next   = result;
    pass_we       = 1'b0;
    pass_waddr    = {r_ext[AB-1:0], c_ext[AB-1:0]};
    pass_wdata    = item.passable;
    vis_we        = 1'b0;
    vis_waddr     = nb_addr;
    vis_wdata     = epoch;
    stk_we        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (item.kind)
            KIND_LOAD: begin
              pass_we     = load_ok;
              done_next   = 1'b1;
              result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                              pushed_count: 4'd0, status: ST_LOADED};
            end
            KIND_START: begin
              cur_row_next  = r_ext;
              cur_col_next  = c_ext;
              goal_row_next = item.goal_row;
              goal_col_next = item.goal_col;
              count_next    = '0;
              active_next   = 1'b0;
              if (epoch == '1) begin
                clr_addr_next = '0;
                clr_mark_next = 1'b1;
                state_next    = S_CLEAR;
              end else begin
                epoch_next = epoch + EPOCH_W'(1);
                state_next = S_MARK;
              end
            end
            default: begin
              if (item.kind == KIND_STEP && active) begin
                if (cur_row == CW'(goal_row) && cur_col == CW'(goal_col)) begin
                  active_next = 1'b0;
                  done_next   = 1'b1;
                  result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                                  pushed_count: 4'd0, status: ST_GOAL};
                end else begin
                  k_next      = 3'd0;
                  pushed_next = 4'd0;
                  state_next  = S_NB_RD;
                end
              end else begin
                done_next   = 1'b1;
                result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                                pushed_count: 4'd0, status: ST_IDLE};
              end
            end
          endcase
        end
      end
      S_CLEAR: begin
        vis_we        = 1'b1;
        vis_waddr     = clr_addr;
        vis_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == '1) begin
          epoch_next    = EPOCH_W'(1);
          clr_mark_next = 1'b0;
          state_next    = clr_mark ? S_MARK : S_IDLE;
        end
      end
      S_MARK: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (({1'b0, cur_row} < side) && ({1'b0, cur_col} < side)) begin
          vis_we      = 1'b1;
          vis_waddr   = {cur_row[AB-1:0], cur_col[AB-1:0]};
          active_next = 1'b1;
          result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                          pushed_count: 4'd0, status: ST_STARTED};
        end else begin
          result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                          pushed_count: 4'd0, status: ST_NOTFOUND};
        end
      end
      S_NB_RD: begin
        if (nb_in) begin
          nb_addr_next = nb_addr_c;
          state_next   = S_NB_CHK;
        end else if (k == 3'd7) begin
          state_next = S_POP;
        end else begin
          k_next = k + 3'd1;
        end
      end
      S_NB_CHK: begin
        if (pass_rd && (vis_rd != epoch)) begin
          vis_we      = 1'b1;
          pushed_next = pushed + 4'd1;
          if (count < CNT_W'(CELLS)) begin
            stk_we     = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        if (k == 3'd7) begin
          state_next = S_POP;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_NB_RD;
        end
      end
      S_POP: begin
        if (count == '0) begin
          active_next = 1'b0;
          done_next   = 1'b1;
          state_next  = S_IDLE;
          result_next = '{pos_row: cur_row[5:0], pos_col: cur_col[5:0],
                          pushed_count: pushed, status: ST_NOTFOUND};
        end else begin
          count_next = cnt_dec;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_row_next = pop_row;
        cur_col_next = pop_col;
        done_next    = 1'b1;
        state_next   = S_IDLE;
        if (pop_row == CW'(goal_row) && pop_col == CW'(goal_col)) begin
          active_next = 1'b0;
          result_next = '{pos_row: pop_row[5:0], pos_col: pop_col[5:0],
                          pushed_count: pushed, status: ST_GOAL};
        end else begin
          result_next = '{pos_row: pop_row[5:0], pos_col: pop_col[5:0],
                          pushed_count: pushed, status: ST_MOVED};
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= 3'd0;
      epoch    <= '0;
      clr_addr <= '0;
      clr_mark <= 1'b0;
      cur_row  <= '0;
      cur_col  <= '0;
      goal_row <= '0;
      goal_col <= '0;
      count    <= '0;
      active   <= 1'b0;
      pushed   <= 4'd0;
      side     <= SW'(SIDE_RST);
      done     <= 1'b0;
    end else begin
      k        <= k_next;
      epoch    <= epoch_next;
      clr_addr <= clr_addr_next;
      clr_mark <= clr_mark_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      goal_row <= goal_row_next;
      goal_col <= goal_col_next;
      count    <= count_next;
      active   <= active_next;
      pushed   <= pushed_next;
      side     <= side_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    nb_addr <= nb_addr_next;
    result  <= result_next;
  end

endmodule

/* rtl/core/gdfs_ram.sv */
// generic single write port, single read port ram with registered read
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/gdfs_nbr.sv */
// shared neighbour unit: offset add, bounds compare and cell address
module gdfs_nbr #(
  parameter int MAX_SIDE = 64
) (
  input  logic [((($clog2(MAX_SIDE)) > 6) ? $clog2(MAX_SIDE) : 6)-1:0] cur_row,
  input  logic [((($clog2(MAX_SIDE)) > 6) ? $clog2(MAX_SIDE) : 6)-1:0] cur_col,
  input  logic [2:0]                                                  k,
  input  logic [((($clog2(MAX_SIDE)) > 6) ? $clog2(MAX_SIDE) : 6):0]   side,
  output logic                                                        in_bounds,
  output logic [2*$clog2(MAX_SIDE)-1:0]                               addr
);
  import gdfs_pkg::*;

  localparam int AB = $clog2(MAX_SIDE);
  localparam int CW = (AB > 6) ? AB : 6;

  logic signed [1:0] dr;
  logic signed [1:0] dc;
  logic [CW:0]       nr;
  logic [CW:0]       nc;

  always_comb begin
    dr = nb_dr(k);
    dc = nb_dc(k);
    // below zero wraps to all ones, which is never under side
    nr = {1'b0, cur_row} + {{(CW-1){dr[1]}}, dr};
    nc = {1'b0, cur_col} + {{(CW-1){dc[1]}}, dc};
    in_bounds = (nr < side) && (nc < side);
    addr = {nr[AB-1:0], nc[AB-1:0]};
  end

endmodule

/* rtl/core/gdfs_checker.sv */
// port-level checks on the grid depth-first search, bound to the top level
module gdfs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input gdfs_pkg::item_t   item,
  input logic              done,
  input gdfs_pkg::result_t result
);
  import gdfs_pkg::*;

  // clearing pass follows reset
  a_busy_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("block not busy right after reset");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind == KIND_LOAD |=> done && result.status == ST_LOADED)
    else $error("load beat did not complete in one cycle");

  // a result beat follows either an accepted item or a busy cycle
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst) |-> $past(start && !busy) || $past(busy))
    else $error("result beat without an item in work");

  a_pushed_only_on_step: assert property (@(posedge clk) disable iff (rst)
    done && (result.pushed_count != 4'd0) |->
      (result.status == ST_MOVED || result.status == ST_GOAL ||
       result.status == ST_NOTFOUND) && result.pushed_count <= 4'd8)
    else $error("pushed count out of place");

endmodule

bind grid_depth_first_search gdfs_checker u_gdfs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done),
  .result(result)
);

/* test/tb_grid_depth_first_search.sv */
`timescale 1ns / 1ps
// self-checking testbench for grid_depth_first_search with a search predictor and scoreboard
module tb_grid_depth_first_search;
  import gdfs_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int GRID_MAX = 64;
  localparam int ITEM_TARGET = 1650;
  localparam int WATCHDOG_LIMIT = 20000;

  class dfs_checker;
    logic [6:0] side_reg;
    bit passable_map [GRID_MAX*GRID_MAX];
    bit loaded_map [GRID_MAX*GRID_MAX];
    bit visited_map [GRID_MAX*GRID_MAX];
    logic [11:0] pending_cells [$];
    logic [5:0] cur_row, cur_col, goal_row, goal_col;
    bit active;
    result_t expected_results [$];
    int unsigned mismatches;
    int unsigned status_count [6];

    function new();
      side_reg = 7'd64;
      cur_row = '0;
      cur_col = '0;
      goal_row = '0;
      goal_col = '0;
      active = 1'b0;
      mismatches = 0;
    endfunction

    function int side();
      if (side_reg < 7'd1) return 1;
      if (side_reg > 7'(GRID_MAX)) return GRID_MAX;
      return int'(side_reg);
    endfunction

    function int row_step(int k);
      if (k <= 2) return -1;
      if (k == 3 || k == 7) return 0;
      return 1;
    endfunction

    function int col_step(int k);
      if (k == 0 || k >= 6) return -1;
      if (k == 1 || k == 5) return 0;
      return 1;
    endfunction

    function bit at_goal();
      return cur_row == goal_row && cur_col == goal_col;
    endfunction

    // first in-bounds neighbour that a step would read before it was ever loaded
    function bit needs_load(output logic [5:0] r, output logic [5:0] c);
      int nr, nc, s;
      s = side();
      r = '0;
      c = '0;
      if (!active || at_goal()) return 1'b0;
      for (int k = 0; k < 8; k++) begin
        nr = int'(cur_row) + row_step(k);
        nc = int'(cur_col) + col_step(k);
        if (nr >= 0 && nc >= 0 && nr < s && nc < s && !loaded_map[nr*GRID_MAX+nc]) begin
          r = 6'(nr);
          c = 6'(nc);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      result_t want;
      int nr, nc, s, idx;
      logic [11:0] popped;
      s = side();
      want.pushed_count = '0;
      case (it.kind)
        KIND_LOAD: begin
          passable_map[{it.cell_row, it.cell_col}] = it.passable;
          loaded_map[{it.cell_row, it.cell_col}] = 1'b1;
          want.status = ST_LOADED;
        end
        KIND_START: begin
          visited_map = '{default: 1'b0};
          pending_cells.delete();
          cur_row = it.cell_row;
          cur_col = it.cell_col;
          goal_row = it.goal_row;
          goal_col = it.goal_col;
          if (int'(cur_row) >= s || int'(cur_col) >= s) begin
            active = 1'b0;
            want.status = ST_NOTFOUND;
          end else begin
            visited_map[{cur_row, cur_col}] = 1'b1;
            active = 1'b1;
            want.status = ST_STARTED;
          end
        end
        default: begin
          if (it.kind != KIND_STEP || !active) begin
            want.status = ST_IDLE;
          end else if (at_goal()) begin
            active = 1'b0;
            want.status = ST_GOAL;
          end else begin
            for (int k = 0; k < 8; k++) begin
              nr = int'(cur_row) + row_step(k);
              nc = int'(cur_col) + col_step(k);
              if (nr < 0 || nc < 0 || nr >= s || nc >= s) continue;
              idx = nr * GRID_MAX + nc;
              if (passable_map[idx] && !visited_map[idx]) begin
                visited_map[idx] = 1'b1;
                pending_cells.push_back(12'(idx));
                want.pushed_count = want.pushed_count + 4'd1;
              end
            end
            if (pending_cells.size() == 0) begin
              active = 1'b0;
              want.status = ST_NOTFOUND;
            end else begin
              popped = pending_cells.pop_back();
              cur_row = popped[11:6];
              cur_col = popped[5:0];
              if (at_goal()) begin
                active = 1'b0;
                want.status = ST_GOAL;
              end else begin
                want.status = ST_MOVED;
              end
            end
          end
        end
      endcase
      want.pos_row = cur_row;
      want.pos_col = cur_col;
      expected_results.push_back(want);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result beat with nothing expected (row %0d col %0d status %0d)",
                         got.pos_row, got.pos_col, got.status));
        return;
      end
      want = expected_results.pop_front();
      if (want.status <= ST_IDLE) status_count[want.status]++;
      if (got.pos_row !== want.pos_row)
        report($sformatf("pos_row %0d, expected %0d", got.pos_row, want.pos_row));
      if (got.pos_col !== want.pos_col)
        report($sformatf("pos_col %0d, expected %0d", got.pos_col, want.pos_col));
      if (got.pushed_count !== want.pushed_count)
        report($sformatf("pushed_count %0d, expected %0d", got.pushed_count,
                         want.pushed_count));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  dfs_checker tracker = new();
  int unsigned counted_items;
  int unsigned phase;
  int unsigned pass_pct;
  int unsigned idle_cycles;
  bit no_gaps;
  logic [6:0] side_list [16] = '{7'd5, 7'd1, 7'd8, 7'd3, 7'd0, 7'd12, 7'd2, 7'd64,
                                 7'd6, 7'd127, 7'd4, 7'd20, 7'd7, 7'd2, 7'd9, 7'd32};

  grid_depth_first_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("grid_depth_first_search regression: fail");
        $finish;
      end
    end
  end

  task automatic issue(input item_t it);
    int unsigned gap, pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(30, 150);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    counted_items++;
    tracker.note_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_side(input logic [6:0] value);
    drain();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.side_reg = value;
  endtask

  function automatic item_t make_item(logic [1:0] kind, logic [5:0] r, logic [5:0] c,
                                      logic p, logic [5:0] gr, logic [5:0] gc);
    item_t it;
    it.kind = kind;
    it.cell_row = r;
    it.cell_col = c;
    it.passable = p;
    it.goal_row = gr;
    it.goal_col = gc;
    return it;
  endfunction

  // load any unwritten neighbour the step would read, then step
  task automatic safe_step();
    item_t it;
    logic [5:0] r, c;
    while (tracker.needs_load(r, c)) begin
      it = item_t'($urandom);
      it.kind = KIND_LOAD;
      it.cell_row = r;
      it.cell_col = c;
      it.passable = ($urandom_range(0, 99) < pass_pct);
      issue(it);
    end
    it = item_t'($urandom);
    it.kind = KIND_STEP;
    issue(it);
  endtask

  task automatic run_search();
    item_t it;
    int s, g, steps, limit;
    int unsigned pick;
    s = tracker.side();
    it = item_t'($urandom);
    it.kind = KIND_START;
    if ($urandom_range(0, 99) < 88) begin
      it.cell_row = 6'($urandom_range(0, s - 1));
      it.cell_col = 6'($urandom_range(0, s - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.goal_row = 6'($urandom_range(0, s - 1));
      it.goal_col = 6'($urandom_range(0, s - 1));
    end else if (pick < 65) begin
      g = int'(it.cell_row) + int'($urandom_range(0, 6)) - 3;
      it.goal_row = 6'((g < 0) ? 0 : ((g > 63) ? 63 : g));
      g = int'(it.cell_col) + int'($urandom_range(0, 6)) - 3;
      it.goal_col = 6'((g < 0) ? 0 : ((g > 63) ? 63 : g));
    end else if (pick < 75) begin
      it.goal_row = it.cell_row;
      it.goal_col = it.cell_col;
    end
    issue(it);
    limit = (s <= 8) ? 80 : 40;
    steps = 0;
    while (tracker.active && steps < limit && counted_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        it = item_t'($urandom);
        it.kind = KIND_LOAD;
        issue(it);
      end else if (pick == 1) begin
        it = item_t'($urandom);
        it.kind = KIND_NOP;
        issue(it);
      end else begin
        safe_step();
      end
      steps++;
    end
    if ($urandom_range(0, 2) == 0) safe_step();
  endtask

  initial begin
    item_t it;
    int s;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    counted_items = 0;
    phase = 0;
    pass_pct = 60;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: corner loads, tiny grid searches, out-of-grid start and goal, side change mid-search
    issue(make_item(KIND_LOAD, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0));
    issue(make_item(KIND_LOAD, 6'd63, 6'd63, 1'b0, 6'd63, 6'd63));
    write_side(7'd2);
    issue(make_item(KIND_LOAD, 6'd0, 6'd1, 1'b1, 6'd0, 6'd0));
    issue(make_item(KIND_LOAD, 6'd1, 6'd0, 1'b0, 6'd0, 6'd0));
    issue(make_item(KIND_LOAD, 6'd1, 6'd1, 1'b1, 6'd0, 6'd0));
    issue(make_item(KIND_START, 6'd0, 6'd0, 1'b0, 6'd1, 6'd1));
    safe_step();
    safe_step();
    issue(make_item(KIND_NOP, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63));
    issue(make_item(KIND_START, 6'd5, 6'd5, 1'b1, 6'd0, 6'd0));
    issue(make_item(KIND_START, 6'd1, 6'd1, 1'b0, 6'd1, 6'd1));
    safe_step();
    issue(make_item(KIND_START, 6'd0, 6'd0, 1'b0, 6'd40, 6'd40));
    repeat (3) safe_step();
    issue(make_item(KIND_START, 6'd0, 6'd0, 1'b0, 6'd63, 6'd63));
    safe_step();
    write_side(7'd1);
    safe_step();
    safe_step();

    // random phases, one grid side per phase
    while (counted_items < ITEM_TARGET) begin
      write_side(side_list[phase % 16]);
      s = tracker.side();
      pass_pct = (s <= 8) ? 60 : 35;
      no_gaps = (phase % 4 == 3);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) safe_step();
      end
      repeat ($urandom_range(2, 8)) begin
        it = item_t'($urandom);
        it.kind = KIND_LOAD;
        issue(it);
      end
      repeat ($urandom_range(2, 5)) run_search();
      phase++;
    end

    drain();
    repeat (30) @(posedge clk);
    if (tracker.expected_results.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.expected_results.size()));
    $display("run: %0d items over %0d grid side settings, loads, starts and steps mixed",
             counted_items, phase + 2);
    $display("run: %0d moves, %0d goals, %0d not found, %0d idle, %0d loads, %0d starts",
             tracker.status_count[ST_MOVED], tracker.status_count[ST_GOAL],
             tracker.status_count[ST_NOTFOUND], tracker.status_count[ST_IDLE],
             tracker.status_count[ST_LOADED], tracker.status_count[ST_STARTED]);
    if (tracker.mismatches == 0) begin
      $display("grid_depth_first_search regression: pass");
    end else begin
      $display("grid_depth_first_search regression: fail");
    end
    $finish;
  end

endmodule
